/* hdl/ptm_pkg.sv */
// ptm_pkg: item types, opcodes, status codes and register indexes for the
// page table mapper. Used by hdl/page_table_mapper_top.sv; depends on nothing.
package ptm_pkg;

    localparam int ADDR_W     = 48;
    localparam int PG_OFS_W   = 12;
    localparam int PG_W       = ADDR_W - PG_OFS_W;
    localparam int ENTRY_W    = 64;
    localparam int SLOT_W     = 9;
    localparam int TFLAG_W    = 12;

    localparam logic [1:0] OP_MAP   = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_FAULT = 2'd2;

    localparam logic [5:0] FAULT_L3_XLAT = 6'h07;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_KERN_FULL = 3'd1;
    localparam logic [2:0] ST_USER_FULL = 3'd2;
    localparam logic [2:0] ST_NO_FRAME  = 3'd3;
    localparam logic [2:0] ST_BAD_FAULT = 3'd4;

    localparam logic [1:0] REG_POOL_BASE   = 2'd0;
    localparam logic [1:0] REG_TABLE_FLAGS = 2'd1;
    localparam logic [1:0] REG_PAGE_FLAGS  = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [ADDR_W-1:0] virt_addr;
        logic [ADDR_W-1:0] phys_addr;
        logic [5:0]        fault_status;
    } req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [ADDR_W-1:0] frame_addr;
        logic [2:0]        tables_added;
    } rsp_t;

endpackage

/* hdl/page_table_mapper_top.sv */
// page_table_mapper_top: four-level page table walker with a first-free frame
// allocator, table store in one synchronous RAM. Depends on hdl/ptm_pkg.sv.
//
//  channel | signals                                  | item
//  --------+------------------------------------------+------------------------
//  req     | req_valid, req_ready, req                | map / free / fault
//  rsp     | rsp_valid, rsp_ready, rsp                | status, frame, tables
//  apb     | psel penable pwrite paddr pwdata prdata  | pool_base (0x00),
//          | pready (always high)                     | table_flags (0x08),
//          |                                          | page_flags (0x10)
//
// One item at a time. Each allocation adds a scan of the used bitmap (one
// frame a cycle, up to POOL_PAGES) plus a clear of the new frame through
// the RAM write port, and a worst-case fault item makes up to five allocations.
// Reset clears the bitmap, root, counts, pool base and page flags and sets
// table flags to 3; table RAM has no reset, every frame is cleared when it
// is allocated. A result waiting on rsp_ready does not stop the next item
// from being accepted; only its own result waits.
// POOL_PAGES must be a power of two (table addresses wrap modulo the pool).
module page_table_mapper_top #(
    parameter int POOL_PAGES     = 64,
    parameter int MAX_LIST_PAGES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  ptm_pkg::req_t       req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output ptm_pkg::rsp_t       rsp,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    localparam int PIDX_W = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam int MEM_AW = PIDX_W + ptm_pkg::SLOT_W;
    localparam int CNT_W  = $clog2(MAX_LIST_PAGES + 1);
    localparam int PG_W   = ptm_pkg::PG_W;
    localparam int AW     = ptm_pkg::ADDR_W;

    typedef enum logic [3:0] {
        S_IDLE, S_MAP, S_SCAN, S_CLR, S_POST, S_RD, S_RDW, S_LEAF, S_DONE
    } state_t;

    // what the frame being allocated is for
    typedef enum logic [1:0] {P_PAGE, P_ROOT, P_TABLE} purpose_t;

    // config registers
    logic [AW-1:0]                 pool_base_reg;
    logic [ptm_pkg::TFLAG_W-1:0]   table_flags_reg;
    logic [ptm_pkg::ENTRY_W-1:0]   page_flags_reg;

    // control
    state_t                        state_reg;
    purpose_t                      purpose_reg;
    logic [POOL_PAGES-1:0]         used_reg;
    logic [AW-1:0]                 root_reg;
    logic [CNT_W-1:0]              kcnt_reg;
    logic [CNT_W-1:0]              ucnt_reg;
    logic [PIDX_W-1:0]             scan_idx_reg;
    logic [ptm_pkg::SLOT_W-1:0]    clr_cnt_reg;
    logic [PIDX_W-1:0]             cur_reg;
    logic [1:0]                    lvl_reg;
    logic [MEM_AW-1:0]             slot_reg;
    logic                          rsp_valid_reg;

    // item payload
    logic [AW-1:0]                 va_reg;
    logic [AW-1:0]                 leaf_frame_reg;
    logic [2:0]                    status_reg;
    logic [2:0]                    added_reg;
    logic [AW-1:0]                 frame_out_reg;
    ptm_pkg::rsp_t                 rsp_reg;

    // table store
    logic [ptm_pkg::ENTRY_W-1:0]   mem [POOL_PAGES * 512];
    logic [ptm_pkg::ENTRY_W-1:0]   rd_data_reg;
    logic                          mem_we;
    logic [MEM_AW-1:0]             mem_waddr;
    logic [ptm_pkg::ENTRY_W-1:0]   mem_wdata;
    logic [MEM_AW-1:0]             mem_raddr;
    logic [ptm_pkg::SLOT_W-1:0]    va_slice;

    logic [PG_W-1:0]               base_pg;
    logic [AW-1:0]                 alloc_addr;
    logic [PG_W-1:0]               rel_diff;
    logic                          rel_hit;
    logic                          cfg_wr;

    // frame index of a page number, wrapped onto the pool
    function automatic logic [PIDX_W-1:0] pidx(input logic [PG_W-1:0] pg,
                                               input logic [PG_W-1:0] base);
        logic [PG_W-1:0] d;
        d = pg - base;
        return d[PIDX_W-1:0];
    endfunction

    assign base_pg    = pool_base_reg[AW-1:ptm_pkg::PG_OFS_W];
    assign alloc_addr = {base_pg + PG_W'(scan_idx_reg), {ptm_pkg::PG_OFS_W{1'b0}}};
    assign rel_diff   = req.phys_addr[AW-1:ptm_pkg::PG_OFS_W] - base_pg;
    assign rel_hit    = (req.phys_addr[AW-1:ptm_pkg::PG_OFS_W] >= base_pg) &&
                        (rel_diff < PG_W'(POOL_PAGES));

    //------------------------------------------------------------------
    // APB config port
    //------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[4:3])
            ptm_pkg::REG_POOL_BASE:   prdata = {16'b0, pool_base_reg};
            ptm_pkg::REG_TABLE_FLAGS: prdata = {52'b0, table_flags_reg};
            ptm_pkg::REG_PAGE_FLAGS:  prdata = page_flags_reg;
            default:                  prdata = 64'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg   <= '0;
            table_flags_reg <= ptm_pkg::TFLAG_W'(3);
            page_flags_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:3])
                ptm_pkg::REG_POOL_BASE:   pool_base_reg   <= pwdata[AW-1:0];
                ptm_pkg::REG_TABLE_FLAGS: table_flags_reg <= pwdata[ptm_pkg::TFLAG_W-1:0];
                ptm_pkg::REG_PAGE_FLAGS:  page_flags_reg  <= pwdata;
                default:                  ;
            endcase
        end
    end

    //------------------------------------------------------------------
    // Table RAM: one write port, one registered read port
    //------------------------------------------------------------------
    always_comb
    begin
        case (lvl_reg)
            2'd0:    va_slice = va_reg[47:39];
            2'd1:    va_slice = va_reg[38:30];
            default: va_slice = va_reg[29:21];
        endcase
    end

    assign mem_raddr = {cur_reg, va_slice};

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = {scan_idx_reg, clr_cnt_reg};
        mem_wdata = '0;
        case (state_reg)
            S_CLR:
            begin
                mem_we = 1'b1;
            end
            S_POST:
            begin
                mem_we    = (purpose_reg == P_TABLE);
                mem_waddr = slot_reg;
                mem_wdata = {16'b0, alloc_addr | {36'b0, table_flags_reg}};
            end
            S_LEAF:
            begin
                mem_we    = 1'b1;
                mem_waddr = {cur_reg, va_reg[20:12]};
                mem_wdata = {16'b0, leaf_frame_reg} | page_flags_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    //------------------------------------------------------------------
    // Sequencer
    //------------------------------------------------------------------
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            purpose_reg   <= P_PAGE;
            used_reg      <= '0;
            root_reg      <= '0;
            kcnt_reg      <= '0;
            ucnt_reg      <= '0;
            scan_idx_reg  <= '0;
            clr_cnt_reg   <= '0;
            cur_reg       <= '0;
            lvl_reg       <= '0;
            slot_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // S_DONE reloads the result register itself
            if (rsp_valid_reg && rsp_ready && (state_reg != S_DONE))
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        va_reg         <= req.virt_addr;
                        leaf_frame_reg <= req.phys_addr;
                        added_reg      <= '0;
                        frame_out_reg  <= '0;
                        case (req.opcode)
                            ptm_pkg::OP_MAP:
                            begin
                                status_reg <= ptm_pkg::ST_OK;
                                state_reg  <= S_MAP;
                            end
                            ptm_pkg::OP_FREE:
                            begin
                                status_reg <= ptm_pkg::ST_OK;
                                state_reg  <= S_DONE;
                                if (rel_hit)
                                    used_reg[rel_diff[PIDX_W-1:0]] <= 1'b0;
                            end
                            ptm_pkg::OP_FAULT:
                            begin
                                if (req.fault_status == ptm_pkg::FAULT_L3_XLAT)
                                begin
                                    status_reg   <= ptm_pkg::ST_OK;
                                    purpose_reg  <= P_PAGE;
                                    scan_idx_reg <= '0;
                                    state_reg    <= S_SCAN;
                                end
                                else
                                begin
                                    status_reg <= ptm_pkg::ST_BAD_FAULT;
                                    state_reg  <= S_DONE;
                                end
                            end
                            default:
                            begin
                                status_reg <= ptm_pkg::ST_BAD_FAULT;
                                state_reg  <= S_DONE;
                            end
                        endcase
                    end
                end

                S_MAP:
                begin
                    lvl_reg <= '0;
                    if (root_reg == '0)
                    begin
                        if (kcnt_reg >= CNT_W'(MAX_LIST_PAGES))
                        begin
                            status_reg <= ptm_pkg::ST_KERN_FULL;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            purpose_reg  <= P_ROOT;
                            scan_idx_reg <= '0;
                            state_reg    <= S_SCAN;
                        end
                    end
                    else
                    begin
                        cur_reg   <= pidx(root_reg[AW-1:ptm_pkg::PG_OFS_W], base_pg);
                        state_reg <= S_RD;
                    end
                end

                // first-free search, one frame a cycle
                S_SCAN:
                begin
                    if (!used_reg[scan_idx_reg])
                    begin
                        used_reg[scan_idx_reg] <= 1'b1;
                        clr_cnt_reg <= '0;
                        state_reg   <= S_CLR;
                    end
                    else if (scan_idx_reg == PIDX_W'(POOL_PAGES - 1))
                    begin
                        status_reg <= ptm_pkg::ST_NO_FRAME;
                        state_reg  <= S_DONE;
                    end
                    else
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                end

                S_CLR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == '1)
                        state_reg <= S_POST;
                end

                S_POST:
                begin
                    case (purpose_reg)
                        P_PAGE:
                        begin
                            leaf_frame_reg <= alloc_addr;
                            state_reg      <= S_MAP;
                        end
                        P_ROOT:
                        begin
                            root_reg  <= alloc_addr;
                            kcnt_reg  <= kcnt_reg + 1'b1;
                            added_reg <= added_reg + 3'd1;
                            cur_reg   <= scan_idx_reg;
                            state_reg <= S_RD;
                        end
                        default:
                        begin
                            // parent entry already written this cycle
                            if (kcnt_reg >= CNT_W'(MAX_LIST_PAGES))
                            begin
                                // a frame address that wrapped below the base is not released
                                if (alloc_addr[AW-1:ptm_pkg::PG_OFS_W] >= base_pg)
                                    used_reg[scan_idx_reg] <= 1'b0;
                                status_reg <= ptm_pkg::ST_KERN_FULL;
                                state_reg  <= S_DONE;
                            end
                            else
                            begin
                                kcnt_reg  <= kcnt_reg + 1'b1;
                                added_reg <= added_reg + 3'd1;
                                cur_reg   <= scan_idx_reg;
                                lvl_reg   <= lvl_reg + 2'd1;
                                state_reg <= (lvl_reg == 2'd2) ? S_LEAF : S_RD;
                            end
                        end
                    endcase
                end

                S_RD:
                begin
                    slot_reg  <= mem_raddr;
                    state_reg <= S_RDW;
                end

                S_RDW:
                begin
                    if (rd_data_reg == '0)
                    begin
                        purpose_reg  <= P_TABLE;
                        scan_idx_reg <= '0;
                        state_reg    <= S_SCAN;
                    end
                    else
                    begin
                        cur_reg   <= pidx(rd_data_reg[AW-1:ptm_pkg::PG_OFS_W], base_pg);
                        lvl_reg   <= lvl_reg + 2'd1;
                        state_reg <= (lvl_reg == 2'd2) ? S_LEAF : S_RD;
                    end
                end

                S_LEAF:
                begin
                    frame_out_reg <= leaf_frame_reg;
                    if (ucnt_reg >= CNT_W'(MAX_LIST_PAGES))
                        status_reg <= ptm_pkg::ST_USER_FULL;
                    else
                        ucnt_reg <= ucnt_reg + 1'b1;
                    state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_reg.status       <= status_reg;
                        rsp_reg.frame_addr   <= frame_out_reg;
                        rsp_reg.tables_added <= added_reg;
                        rsp_valid_reg        <= 1'b1;
                        state_reg            <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_kcnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        kcnt_reg <= CNT_W'(MAX_LIST_PAGES))
        else $error("kernel page count over limit");

    a_ucnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        ucnt_reg <= CNT_W'(MAX_LIST_PAGES))
        else $error("user page count over limit");

    a_root_used: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POST && purpose_reg == P_ROOT) |=> (root_reg != '0 ||
        $past(alloc_addr) == '0))
        else $error("root not recorded after allocation");

    a_rsp_stat: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ptm_pkg::ST_BAD_FAULT) |-> (rsp.tables_added == 3'd0))
        else $error("rejected item reports tables");
`endif

endmodule

/* tb/page_table_mapper_top_test.sv */
// Self-checking testbench for page_table_mapper_top: drives map, free, fault and unused-opcode items,
// predicts every result with its own model of the tables and the frame bitmap, and checks.
// Depends on hdl/ptm_pkg.sv and hdl/page_table_mapper_top.sv.
`timescale 1ns / 100ps

module page_table_mapper_top_test;

    localparam int          POOL       = 64;
    localparam int          LIST_MAX   = 16;
    localparam int          ENTRIES    = 512;
    localparam logic [1:0]  OP_UNUSED  = 2'd3;
    // Base steps that keep every table frame on the same pool index.
    localparam logic [47:0] BASE_STEP  = 48'h4_0000;
    localparam logic [4:0]  ADDR_POOL  = 5'h00;
    localparam logic [4:0]  ADDR_TFLAG = 5'h08;
    localparam logic [4:0]  ADDR_PFLAG = 5'h10;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_ready;
    ptm_pkg::req_t req = '0;
    logic          rsp_valid;
    logic          rsp_ready = 1'b0;
    ptm_pkg::rsp_t rsp;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [4:0]    paddr = '0;
    logic [63:0]   pwdata = '0;
    logic [63:0]   prdata;
    logic          pready;

    page_table_mapper_top dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop if the block hangs.
    initial
    begin
        #200ms;
        $display("tb: failure");
        $finish;
    end

    // ---------------- mapper model ----------------
    logic [47:0] mdl_pool_base = '0;
    logic [11:0] mdl_table_flags = 12'd3;
    logic [63:0] mdl_page_flags = '0;
    bit          frame_busy [POOL];
    logic [63:0] table_mem [POOL*ENTRIES];
    logic [47:0] root_addr = '0;
    int          kern_tbl_cnt = 0;
    int          user_pg_cnt = 0;

    ptm_pkg::rsp_t pending_results [$];
    int          fail_count = 0;
    int          items_sent = 0;
    int          reg_writes = 0;
    int          status_seen [8];
    bit          calm = 1'b0;     // no idling on either side once set
    logic [47:0] hot_va [8];

    function automatic logic [47:0] base_eff();
        return {mdl_pool_base[47:12], 12'h000};
    endfunction

    function automatic int pool_index(logic [47:0] a);
        logic [47:0] off;
        off = {a[47:12], 12'h000} - base_eff();
        return int'(off[17:12]);
    endfunction

    // First free frame; the new frame is cleared.
    function automatic bit grab_frame(output logic [47:0] a);
        for (int i = 0; i < POOL; i++)
        begin
            if (!frame_busy[i])
            begin
                frame_busy[i] = 1'b1;
                for (int j = 0; j < ENTRIES; j++)
                    table_mem[i*ENTRIES + j] = '0;
                a = base_eff() + 48'(i) * 48'd4096;
                return 1'b1;
            end
        end
        a = '0;
        return 1'b0;
    endfunction

    function automatic void drop_frame(logic [47:0] a);
        logic [47:0] off;
        if (a < base_eff())
            return;
        off = a - base_eff();
        if (off[47:12] < POOL)
            frame_busy[off[17:12]] = 1'b0;
    endfunction

    function automatic logic [2:0] walk_and_map(logic [47:0] va, logic [47:0] frame,
                                                inout int added, inout bit leaf);
        logic [47:0] a;
        logic [63:0] e;
        int          cur;
        int          slot;
        if (root_addr == '0)
        begin
            if (kern_tbl_cnt >= LIST_MAX)
                return ptm_pkg::ST_KERN_FULL;
            if (!grab_frame(a))
                return ptm_pkg::ST_NO_FRAME;
            root_addr = a;
            kern_tbl_cnt++;
            added++;
        end
        cur = pool_index(root_addr);
        for (int lvl = 0; lvl < 3; lvl++)
        begin
            slot = cur*ENTRIES + int'((va >> (39 - 9*lvl)) & 48'h1FF);
            e = table_mem[slot];
            if (e == '0)
            begin
                if (!grab_frame(a))
                    return ptm_pkg::ST_NO_FRAME;
                table_mem[slot] = {16'h0, a} | {52'h0, mdl_table_flags};
                if (kern_tbl_cnt >= LIST_MAX)
                begin
                    drop_frame(a);
                    return ptm_pkg::ST_KERN_FULL;
                end
                kern_tbl_cnt++;
                added++;
                cur = pool_index(a);
            end
            else
                cur = pool_index(e[47:0]);
        end
        slot = cur*ENTRIES + int'(va[20:12]);
        table_mem[slot] = {16'h0, frame} | mdl_page_flags;
        leaf = 1'b1;
        if (user_pg_cnt >= LIST_MAX)
            return ptm_pkg::ST_USER_FULL;
        user_pg_cnt++;
        return ptm_pkg::ST_OK;
    endfunction

    function automatic ptm_pkg::rsp_t predict_result(ptm_pkg::req_t r);
        ptm_pkg::rsp_t o;
        int          added;
        bit          leaf;
        logic [47:0] pg;
        o = '0;
        added = 0;
        leaf = 1'b0;
        if (r.opcode == ptm_pkg::OP_MAP)
        begin
            o.status = walk_and_map(r.virt_addr, r.phys_addr, added, leaf);
            if (leaf)
                o.frame_addr = r.phys_addr;
        end
        else if (r.opcode == ptm_pkg::OP_FREE)
            drop_frame(r.phys_addr);
        else if (r.opcode == ptm_pkg::OP_FAULT && r.fault_status == ptm_pkg::FAULT_L3_XLAT)
        begin
            if (!grab_frame(pg))
                o.status = ptm_pkg::ST_NO_FRAME;
            else
            begin
                o.status = walk_and_map({r.virt_addr[47:12], 12'h000}, pg, added, leaf);
                if (leaf)
                    o.frame_addr = pg;
            end
        end
        else
            o.status = ptm_pkg::ST_BAD_FAULT;
        o.tables_added = 3'(added);
        return o;
    endfunction

    // ---------------- drivers ----------------
    task automatic send_item(ptm_pkg::req_t r);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        pending_results.push_back(predict_result(r));
        items_sent++;
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic make_item(logic [1:0] op, logic [47:0] va, logic [47:0] pa,
                             logic [5:0] fs);
        ptm_pkg::req_t r;
        r.opcode = op;
        r.virt_addr = va;
        r.phys_addr = pa;
        r.fault_status = fs;
        send_item(r);
    endtask

    // Register writes only with the block drained.
    task automatic write_reg(logic [4:0] a, logic [63:0] d);
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (a)
            ADDR_POOL:  mdl_pool_base = d[47:0];
            ADDR_TFLAG: mdl_table_flags = d[11:0];
            default:    mdl_page_flags = d;
        endcase
        reg_writes++;
    endtask

    // Result side stalls in random bursts.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 4) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            rsp_ready <= 1'b1;
        end
    end

    // Result checker: every accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        ptm_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with none expected: status %0d", rsp.status);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                status_seen[rsp.status]++;
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    fail_count++;
                end
                if (rsp.frame_addr !== want.frame_addr)
                begin
                    $error("frame_addr: expected %h, got %h", want.frame_addr, rsp.frame_addr);
                    fail_count++;
                end
                if (rsp.tables_added !== want.tables_added)
                begin
                    $error("tables_added: expected %0d, got %0d",
                           want.tables_added, rsp.tables_added);
                    fail_count++;
                end
            end
        end
    end

    // ---------------- tests ----------------
    // Corners: zero-address root, all-ones fields, bad faults, unused opcode,
    // frees inside and outside the pool, remapping through existing tables.
    task automatic test_corners();
        make_item(ptm_pkg::OP_MAP, 48'h0, 48'h0, 6'h0);     // root lands at address zero
        make_item(ptm_pkg::OP_MAP, 48'h0, 48'h1000, 6'h0);  // so a new root is taken
        make_item(ptm_pkg::OP_MAP, '1, '1, '1);
        make_item(ptm_pkg::OP_MAP, '1, 48'h5000, 6'h0);     // tables already there
        make_item(ptm_pkg::OP_FAULT, 48'h1234_5678_9ABC, '1, ptm_pkg::FAULT_L3_XLAT);
        make_item(ptm_pkg::OP_FAULT, 48'h1234_5678_9ABC, '0, 6'h3F); // not a translation fault
        make_item(ptm_pkg::OP_FAULT, 48'h0, 48'h0, 6'h00);
        make_item(OP_UNUSED, '1, '1, ptm_pkg::FAULT_L3_XLAT);
        make_item(ptm_pkg::OP_FREE, '0, '1, '0);             // beyond the pool
        make_item(ptm_pkg::OP_FREE, '0, 48'h3000, '0);
        make_item(ptm_pkg::OP_MAP, 48'h8000_0000_0000, 48'hABCD_E000, '0);
        make_item(ptm_pkg::OP_MAP, 48'h0000_4020_1000, 48'h7000, '0);
    endtask

    // Faults on one page until the pool runs dry (the kernel list is already full
    // on the way), then release every frame.
    task automatic test_exhaustion();
        for (int i = 0; i < POOL + 8; i++)
            make_item(ptm_pkg::OP_FAULT, 48'h0000_7FFF_F000 | 48'($urandom_range(0, 4095)),
                      48'($urandom()), ptm_pkg::FAULT_L3_XLAT);
        make_item(ptm_pkg::OP_MAP, 48'h0000_1111_1000, 48'h2000, '0);  // out of frames
        for (int i = 0; i < POOL; i++)
            make_item(ptm_pkg::OP_FREE, '0,
                      base_eff() + 48'(i) * 48'd4096 + 48'($urandom_range(0, 4095)), '0);
    endtask

    task automatic random_burst(int n);
        logic [47:0] va;
        logic [47:0] pa;
        int          pick;
        for (int k = 0; k < n; k++)
        begin
            va = ($urandom_range(0, 4) != 0) ? hot_va[$urandom_range(0, 7)]
                                             : {$urandom(), 16'($urandom())};
            va = va ^ 48'($urandom_range(0, 15) << 12);
            pa = {16'($urandom()), $urandom()};
            pick = $urandom_range(0, 99);
            if (pick < 35)
                make_item(ptm_pkg::OP_MAP, va, pa, 6'($urandom()));
            else if (pick < 65)
                // mostly frames of the pool, sometimes anywhere
                make_item(ptm_pkg::OP_FREE, va, ($urandom_range(0, 5) != 0)
                          ? base_eff() + 48'($urandom_range(0, POOL-1)) * 48'd4096
                            + 48'($urandom_range(0, 4095))
                          : pa, 6'($urandom()));
            else if (pick < 92)
                make_item(ptm_pkg::OP_FAULT, va, pa,
                          ($urandom_range(0, 4) != 0) ? ptm_pkg::FAULT_L3_XLAT
                                                      : 6'($urandom()));
            else
                make_item(($urandom_range(0, 1) != 0) ? OP_UNUSED : ptm_pkg::OP_FAULT,
                          va, pa, 6'($urandom()));
        end
    endtask

    // Several register settings, the extremes among them; pool moves in
    // whole-pool steps so existing tables stay addressable.
    task automatic test_settings();
        write_reg(ADDR_TFLAG, 64'h0);
        write_reg(ADDR_PFLAG, '1);
        random_burst(150);
        write_reg(ADDR_POOL, 64'h0000_FFFF_FFFC_0FFF);
        write_reg(ADDR_TFLAG, 64'hFFF);
        write_reg(ADDR_PFLAG, 64'h0);
        random_burst(150);
        write_reg(ADDR_POOL, 64'(BASE_STEP * 48'($urandom_range(1, 1000)))
                             | 64'($urandom_range(0, 4095)));
        write_reg(ADDR_TFLAG, 64'($urandom_range(0, 4095)));
        write_reg(ADDR_PFLAG, {$urandom(), $urandom()});
        random_burst(150);
        write_reg(ADDR_POOL, 64'h0);
        write_reg(ADDR_TFLAG, 64'h3);
        random_burst(100);
    endtask

    task automatic test_back_to_back();
        calm = 1'b1;
        random_burst(150);
        req_valid <= 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < 8; i++)
            hot_va[i] = {$urandom(), 16'($urandom())};
        for (int i = 0; i < POOL*ENTRIES; i++)
            table_mem[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corners();
        test_exhaustion();
        test_settings();
        test_back_to_back();

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("tb: %0d items, %0d register writes; results ok %0d, kernel full %0d,",
                 items_sent, reg_writes, status_seen[ptm_pkg::ST_OK],
                 status_seen[ptm_pkg::ST_KERN_FULL]);
        $display("tb: user full %0d, no frame %0d, bad fault %0d",
                 status_seen[ptm_pkg::ST_USER_FULL], status_seen[ptm_pkg::ST_NO_FRAME],
                 status_seen[ptm_pkg::ST_BAD_FAULT]);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
